// ----- rtl/core/dfsst_pkg.sv -----
// Shared types and codes for the depth-first spanning tree block.
`default_nettype none

package dfsst_pkg;

    localparam logic ACT_ADD_EDGE = 1'b0;
    localparam logic ACT_START    = 1'b1;

    typedef struct packed {
        logic exhausted;
        logic hit;
    } scan_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/dfsst_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dfsst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dfsst_scan_unit.sv -----
// Neighbor test unit: checks one candidate column of the current adjacency row.
`default_nettype none

module dfsst_scan_unit import dfsst_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic [MAX_VERTICES-1:0]         row,
    input  wire logic [MAX_VERTICES-1:0]         visited,
    input  wire logic [$clog2(MAX_VERTICES+1)-1:0] idx,
    input  wire logic [$clog2(MAX_VERTICES+1)-1:0] count,
    output scan_status_t                          status
);

    localparam int VW = $clog2(MAX_VERTICES);

    logic [VW-1:0] col;

    assign col              = idx[VW-1:0];
    assign status.exhausted = (idx >= count);
    assign status.hit       = (idx < count) && row[col] && !visited[col];

endmodule

`default_nettype wire

// ----- rtl/core/dfs_spanning_tree_matrix.sv -----
// Top level: adjacency matrix store and depth-first walk sequencer.
// An add-edge transaction does a row read, then a row write, before the next is taken.
// A walk scans the columns of each visited vertex's row in turn, with a row read on every
// entry and resume, a stack read on every return and a finish state at the end.
// Results leave from an output register; a stalled output pauses the walk. Reset
// (synchronous, active low) empties the matrix at once via per-row valid bits and sets
// num_vertices to 16; no clearing pass is needed.
`default_nettype none

module dfs_spanning_tree_matrix import dfsst_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [3:0] start_vertex, [7:4] dst_vertex
    input  wire logic       s_tuser,   // [0] action
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [3:0] parent_vertex, [7:4] child_vertex
    output logic            m_tuser,   // [0] edge_valid
    output logic            m_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_data
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int IW = $clog2(MAX_VERTICES + 1);
    localparam int DW = IW;
    localparam int CW = (IW > 5) ? IW : 5;
    localparam int OW = (VW > 4) ? VW : 4;
    localparam int SW = VW + IW;
    localparam logic [MAX_VERTICES-1:0] BIT0 = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_WR,
        ST_ROW,
        ST_SCAN,
        ST_POP,
        ST_FINISH
    } state_t;

    function automatic logic [3:0] to_port(input logic [VW-1:0] v);
        logic [OW-1:0] t;
        t = OW'(v);
        return t[3:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [4:0]              num_vertices_reg;
    logic [IW-1:0]           count_reg, count_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic                    adj_rv_reg, adj_rv_next;
    logic [VW-1:0]           cur_u_reg, cur_u_next;
    logic [IW-1:0]           cur_i_reg, cur_i_next;
    logic [DW-1:0]           depth_reg, depth_next;
    logic [VW-1:0]           edge_row_reg, edge_row_next;
    logic [VW-1:0]           edge_col_reg, edge_col_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [VW-1:0]           pend_parent_reg, pend_parent_next;
    logic [VW-1:0]           pend_child_reg, pend_child_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [7:0]              m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;
    logic                    m_tlast_reg, m_tlast_next;

    logic                    in_fire;
    logic                    out_free;
    logic [CW-1:0]           sv_ext, dv_ext, num_ext, cnt_clamp;
    logic [DW-1:0]           depth_m1, depth_m2;

    logic                    adj_we, adj_re;
    logic [VW-1:0]           adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
    logic                    stk_we, stk_re;
    logic [VW-1:0]           stk_waddr, stk_raddr;
    logic [SW-1:0]           stk_wdata, stk_rdata;

    scan_status_t            scan;

    dfsst_ram #(
        .WIDTH(MAX_VERTICES),
        .DEPTH(MAX_VERTICES)
    ) u_adj_ram (
        .clk     (aclk),
        .wr_en   (adj_we),
        .wr_addr (adj_waddr),
        .wr_data (adj_wdata),
        .rd_en   (adj_re),
        .rd_addr (adj_raddr),
        .rd_data (adj_rdata)
    );

    dfsst_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_VERTICES)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    dfsst_scan_unit #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_scan (
        .row     (row_reg),
        .visited (visited_reg),
        .idx     (cur_i_reg),
        .count   (count_reg),
        .status  (scan)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign sv_ext    = CW'(s_tdata[3:0]);
    assign dv_ext    = CW'(s_tdata[7:4]);
    assign num_ext   = CW'(num_vertices_reg);
    assign cnt_clamp = (num_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : num_ext;
    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        visited_next     = visited_reg;
        row_valid_next   = row_valid_reg;
        row_next         = row_reg;
        adj_rv_next      = adj_rv_reg;
        cur_u_next       = cur_u_reg;
        cur_i_next       = cur_i_reg;
        depth_next       = depth_reg;
        edge_row_next    = edge_row_reg;
        edge_col_next    = edge_col_reg;
        pend_valid_next  = pend_valid_reg;
        pend_parent_next = pend_parent_reg;
        pend_child_next  = pend_child_reg;
        m_tvalid_next    = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        m_tlast_next     = m_tlast_reg;

        adj_re    = 1'b0;
        adj_raddr = '0;
        adj_we    = 1'b0;
        adj_waddr = edge_row_reg;
        adj_wdata = (adj_rv_reg ? adj_rdata : '0) | (BIT0 << edge_col_reg);
        stk_we    = 1'b0;
        stk_waddr = depth_m1[VW-1:0];
        stk_wdata = {cur_i_reg + IW'(1), cur_u_reg};
        stk_re    = 1'b0;
        stk_raddr = depth_m2[VW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == ACT_ADD_EDGE) begin
                        if (sv_ext < CW'(MAX_VERTICES) && dv_ext < CW'(MAX_VERTICES)) begin
                            adj_re        = 1'b1;
                            adj_raddr     = sv_ext[VW-1:0];
                            edge_row_next = sv_ext[VW-1:0];
                            edge_col_next = dv_ext[VW-1:0];
                            state_next    = ST_EDGE_WR;
                        end
                    end else begin
                        count_next      = cnt_clamp[IW-1:0];
                        visited_next    = '0;
                        pend_valid_next = 1'b0;
                        if (sv_ext < cnt_clamp) begin
                            cur_u_next   = sv_ext[VW-1:0];
                            cur_i_next   = '0;
                            depth_next   = DW'(1);
                            visited_next = BIT0 << sv_ext[VW-1:0];
                            adj_re       = 1'b1;
                            adj_raddr    = sv_ext[VW-1:0];
                            state_next   = ST_ROW;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_EDGE_WR: begin
                adj_we                       = 1'b1;
                row_valid_next[edge_row_reg] = 1'b1;
                state_next                   = ST_IDLE;
            end
            ST_ROW: begin
                row_next   = adj_rv_reg ? adj_rdata : '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan.exhausted) begin
                    depth_next = depth_m1;
                    if (depth_reg == DW'(1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        stk_re     = 1'b1;
                        state_next = ST_POP;
                    end
                end else if (scan.hit) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = {to_port(pend_child_reg), to_port(pend_parent_reg)};
                            m_tuser_next  = 1'b1;
                            m_tlast_next  = 1'b0;
                        end
                        pend_valid_next                     = 1'b1;
                        pend_parent_next                    = cur_u_reg;
                        pend_child_next                     = cur_i_reg[VW-1:0];
                        visited_next[cur_i_reg[VW-1:0]]     = 1'b1;
                        stk_we                              = 1'b1;
                        cur_u_next                          = cur_i_reg[VW-1:0];
                        cur_i_next                          = '0;
                        depth_next                          = depth_reg + DW'(1);
                        adj_re                              = 1'b1;
                        adj_raddr                           = cur_i_reg[VW-1:0];
                        state_next                          = ST_ROW;
                    end
                end else begin
                    cur_i_next = cur_i_reg + IW'(1);
                end
            end
            ST_POP: begin
                cur_u_next = stk_rdata[VW-1:0];
                cur_i_next = stk_rdata[SW-1:VW];
                adj_re     = 1'b1;
                adj_raddr  = stk_rdata[VW-1:0];
                state_next = ST_ROW;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_tdata_next = {to_port(pend_child_reg), to_port(pend_parent_reg)};
                        m_tuser_next = 1'b1;
                    end else begin
                        m_tdata_next = '0;
                        m_tuser_next = 1'b0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (adj_re) begin
            adj_rv_next = row_valid_reg[adj_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        count_reg       <= count_next;
        row_reg         <= row_next;
        adj_rv_reg      <= adj_rv_next;
        cur_u_reg       <= cur_u_next;
        cur_i_reg       <= cur_i_next;
        edge_row_reg    <= edge_row_next;
        edge_col_reg    <= edge_col_next;
        pend_parent_reg <= pend_parent_next;
        pend_child_reg  <= pend_child_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
        m_tlast_reg     <= m_tlast_next;
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            num_vertices_reg <= 5'd16;
            visited_reg      <= '0;
            row_valid_reg    <= '0;
            depth_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            visited_reg    <= visited_next;
            row_valid_reg  <= row_valid_next;
            depth_reg      <= depth_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                num_vertices_reg <= cfg_data;
            end
        end
    end

    // The stack never holds more entries than there are vertices.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_VERTICES))
        else $error("walk stack depth exceeds vertex count");

    // A vertex under scan has a stack entry and is already marked visited.
    a_scan_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (depth_reg != '0) && visited_reg[cur_u_reg])
        else $error("scanning without a visited stack top");

    // Every walk unwinds its stack before new work is taken.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (depth_reg == '0))
        else $error("stack not empty in idle");

    // An empty result is always the last result of its walk.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> m_tlast_reg)
        else $error("empty result without last flag");

    // A tree edge is queued only once its child has been marked visited.
    a_pend_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && state_reg != ST_IDLE) |-> visited_reg[pend_child_reg])
        else $error("pending edge child not visited");

endmodule

`default_nettype wire

// ----- tb/dfs_spanning_tree_matrix_tb.sv -----
// Self-checking testbench that compares depth-first tree edges from the block against its own graph walk.
module dfs_spanning_tree_matrix_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dfsst_pkg::*;

    localparam int VMAX           = 16;
    localparam int MAX_EDGES      = 15;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 50;

    typedef struct {
        logic       action;
        logic [3:0] src;
        logic [3:0] dst;
    } graph_cmd_t;

    typedef struct {
        logic       edge_valid;
        logic [3:0] parent;
        logic [3:0] child;
        logic       last;
    } tree_edge_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = '0;
    logic       s_tuser   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data  = 5'd16;

    graph_cmd_t pending_cmds[$];
    tree_edge_t expected_edges[$];
    graph_cmd_t next_cmd;
    tree_edge_t got_edge;
    tree_edge_t want_edge;

    logic [15:0] adj_rows[VMAX];
    logic [15:0] visited;
    logic [4:0]  vertex_count;

    bit failed       = 1'b0;
    bit idle_on      = 1'b1;
    bit in_fire      = 1'b0;
    int in_gap       = 0;
    int out_gap      = 0;
    int quiet_cycles = 0;

    dfs_spanning_tree_matrix #(
        .MAX_VERTICES(VMAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Walks the stored graph from root and queues the tree edges it discovers.
    task automatic predict_walk(input logic [3:0] root);
        logic [3:0] stk_vertex[VMAX];
        logic [4:0] stk_resume[VMAX];
        int         depth;
        int         n;
        int         cnt;
        int         u;
        int         i;
        bit         found;
        tree_edge_t e;
        cnt     = (int'(vertex_count) > VMAX) ? VMAX : int'(vertex_count);
        visited = '0;
        depth   = 0;
        n       = 0;
        if (int'(root) < cnt) begin
            visited[root] = 1'b1;
            stk_vertex[0] = root;
            stk_resume[0] = '0;
            depth = 1;
        end
        while (depth > 0) begin
            u     = int'(stk_vertex[depth - 1]);
            i     = int'(stk_resume[depth - 1]);
            found = 1'b0;
            while (i < cnt && !found) begin
                if (adj_rows[u][i] && !visited[i]) begin
                    found = 1'b1;
                end else begin
                    i++;
                end
            end
            if (!found) begin
                depth--;
            end else begin
                stk_resume[depth - 1] = 5'(i + 1);
                visited[i] = 1'b1;
                if (n < MAX_EDGES) begin
                    e.edge_valid = 1'b1;
                    e.parent     = 4'(u);
                    e.child      = 4'(i);
                    e.last       = 1'b0;
                    expected_edges.push_back(e);
                    n++;
                end
                if (depth < VMAX) begin
                    stk_vertex[depth] = 4'(i);
                    stk_resume[depth] = '0;
                    depth++;
                end
            end
        end
        if (n == 0) begin
            e.edge_valid = 1'b0;
            e.parent     = '0;
            e.child      = '0;
            e.last       = 1'b1;
            expected_edges.push_back(e);
        end else begin
            e = expected_edges.pop_back();
            e.last = 1'b1;
            expected_edges.push_back(e);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (in_gap > 0) begin
                in_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                in_gap = int'($urandom_range(0, 8));
                s_tvalid <= 1'b0;
            end else begin
                next_cmd = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_cmd.dst, next_cmd.src};
                s_tuser  <= next_cmd.action;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_gap = int'($urandom_range(0, 8));
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
            for (int r = 0; r < VMAX; r++) begin
                adj_rows[r] = '0;
            end
            vertex_count = 5'd16;
            quiet_cycles = 0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                vertex_count = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_ADD_EDGE) begin
                    adj_rows[s_tdata[3:0]][s_tdata[7:4]] = 1'b1;
                end else begin
                    predict_walk(s_tdata[3:0]);
                end
            end
            if (m_tvalid && m_tready) begin
                got_edge.edge_valid = m_tuser;
                got_edge.parent     = m_tdata[3:0];
                got_edge.child      = m_tdata[7:4];
                got_edge.last       = m_tlast;
                if (expected_edges.size() == 0) begin
                    $display("%0t: unexpected result valid=%0d parent=%0d child=%0d last=%0d",
                             $time, got_edge.edge_valid, got_edge.parent, got_edge.child,
                             got_edge.last);
                    failed = 1'b1;
                end else begin
                    want_edge = expected_edges.pop_front();
                    if (got_edge.edge_valid !== want_edge.edge_valid ||
                        got_edge.parent !== want_edge.parent ||
                        got_edge.child !== want_edge.child ||
                        got_edge.last !== want_edge.last) begin
                        $display("%0t: mismatch expected valid=%0d parent=%0d child=%0d last=%0d",
                                 $time, want_edge.edge_valid, want_edge.parent,
                                 want_edge.child, want_edge.last);
                        $display("%0t:          actual   valid=%0d parent=%0d child=%0d last=%0d",
                                 $time, got_edge.edge_valid, got_edge.parent,
                                 got_edge.child, got_edge.last);
                        failed = 1'b1;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic void queue_cmd(input logic action, input logic [3:0] src,
                                      input logic [3:0] dst);
        graph_cmd_t c;
        c.action = action;
        c.src    = src;
        c.dst    = dst;
        pending_cmds.push_back(c);
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_edges.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input logic [4:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++) begin
            queue_cmd(($urandom_range(0, 4) < 2) ? ACT_START : ACT_ADD_EDGE,
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty graph first, then a ring through every vertex that yields the longest tree.
        queue_cmd(ACT_START, 4'd0, 4'd0);
        queue_cmd(ACT_START, 4'd15, 4'd15);
        for (int v = 0; v < 15; v++) begin
            queue_cmd(ACT_ADD_EDGE, 4'(v), 4'(v + 1));
        end
        queue_cmd(ACT_ADD_EDGE, 4'd15, 4'd0);
        queue_cmd(ACT_ADD_EDGE, 4'd3, 4'd4);
        queue_cmd(ACT_ADD_EDGE, 4'd7, 4'd7);
        queue_cmd(ACT_START, 4'd0, 4'd0);
        queue_cmd(ACT_START, 4'd15, 4'd0);
        wait_idle();
        write_vertex_count(5'd31);
        queue_cmd(ACT_START, 4'd9, 4'd6);
        wait_idle();
        write_vertex_count(5'd1);
        queue_cmd(ACT_START, 4'd0, 4'd0);
        queue_cmd(ACT_START, 4'd5, 4'd0);
        wait_idle();
        write_vertex_count(5'd0);
        queue_cmd(ACT_START, 4'd0, 4'd0);
        wait_idle();
        write_vertex_count(5'd4);
        queue_cmd(ACT_START, 4'd2, 4'd0);

        for (int phase = 0; phase < 10; phase++) begin
            wait_idle();
            write_vertex_count(($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                             : 5'($urandom_range(1, 16)));
            idle_on = ($urandom_range(0, 3) != 0);
            queue_random(40);
        end

        wait_idle();
        idle_on = 1'b0;
        write_vertex_count(5'd16);
        queue_random(24);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!failed && expected_edges.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- dfs_spanning_tree_matrix.f -----
rtl/core/dfsst_pkg.sv
rtl/core/dfsst_ram.sv
rtl/core/dfsst_scan_unit.sv
rtl/core/dfs_spanning_tree_matrix.sv
tb/dfs_spanning_tree_matrix_tb.sv
